// ===== hw/rtl/assert_macros.svh =====
// assertion helpers used by ccec_window
// each macro expects aclk and aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ccec_pkg.sv =====
// ---------------------------------------------------------------------------
// ccec_pkg
// Shared types and constants of the current clamp event counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccec_pkg;

    // converter and datapath widths
    localparam int ADC_BITS   = 12;
    localparam int GAIN_W     = 24;
    localparam int CUR_W      = 28;
    localparam int CUR_FRAC_SH = 8;
    localparam int PROD_W     = 16 + GAIN_W;
    localparam int SUM_W      = 44;
    localparam int FILL_W     = 16;
    localparam int TIME_W     = 32;
    localparam int HOLD_W     = 16;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;
    // fall level of 2.0 mA in q8 is 512 = n << 9
    localparam int FALL_SH    = 9;

    localparam logic [CUR_W-1:0] CUR_MAX = {CUR_W{1'b1}};

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_FORCE  = 2'd1,
        OP_ACK    = 2'd2
    } op_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLED   = 3'd0,
        REG_MIN_CODE  = 3'd1,
        REG_GAIN      = 3'd2,
        REG_THRESHOLD = 3'd3,
        REG_WINDOW    = 3'd4,
        REG_HOLDOFF   = 3'd5
    } reg_idx_e;

    typedef struct packed {
        logic                enabled;
        logic [ADC_BITS-1:0] min_code;
        logic [GAIN_W-1:0]   gain;
        logic [CUR_W-1:0]    threshold;
        logic [FILL_W-1:0]   window_samples;
        logic [HOLD_W-1:0]   holdoff_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] now_ms;
        logic [CUR_W-1:0]  cur;
    } item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/current_clamp_event_counter.sv =====
// ---------------------------------------------------------------------------
// current_clamp_event_counter
// Clamps and scales adc samples to mA, averages them over windows and
// counts threshold events with fall detection and a millisecond holdoff.
//
// Usage:
//   - input channel s_*: op (sample, force count, acknowledge), adc_code and
//     now_ms; a word moves when s_valid and s_ready are both high
//   - result channel m_*: one word per input word, showing the state after
//     that input: current_q8, active, event_count, report_pending
//   - config port: cfg_we with cfg_index and cfg_wdata, one write per cycle,
//     issued only while no words are in flight
//   - a word passes the input register, then the result/state register;
//     one word per cycle sustained while m_ready is high, and the input
//     register and the result/state register each hold one word
//   - a stalled m_ready holds the result; the input register still takes
//     one more word, after which s_ready drops
//   - synchronous reset clears the pipeline, event count and window, sets
//     report pending and armed, and loads the register defaults
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module current_clamp_event_counter (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [ccec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ccec_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_op,
    input  wire logic [ccec_pkg::ADC_BITS-1:0]    s_adc_code,
    input  wire logic [ccec_pkg::TIME_W-1:0]      s_now_ms,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [ccec_pkg::CUR_W-1:0]            m_current_q8,
    output logic                                  m_active,
    output logic [ccec_pkg::CNT_W-1:0]            m_event_count,
    output logic                                  m_report_pending
);
    import ccec_pkg::*;

    cfg_t  cfg;
    item_t s1_item;
    logic  s1_valid;
    logic  pass_ready;

    // register file
    ccec_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register with conversion
    ccec_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_adc_code (s_adc_code),
        .s_now_ms   (s_now_ms),
        .pass_ready (pass_ready),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item)
    );

    // window decision and result register
    ccec_window u_win (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .s1_valid         (s1_valid),
        .s1_item          (s1_item),
        .pass_ready       (pass_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_current_q8     (m_current_q8),
        .m_active         (m_active),
        .m_event_count    (m_event_count),
        .m_report_pending (m_report_pending)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ccec_cfg.sv =====
// ---------------------------------------------------------------------------
// ccec_cfg
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccec_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [ccec_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ccec_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output ccec_pkg::cfg_t                        cfg
);
    import ccec_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_ENABLED:   cfg_next.enabled        = cfg_wdata[0];
                REG_MIN_CODE:  cfg_next.min_code       = cfg_wdata[ADC_BITS-1:0];
                REG_GAIN:      cfg_next.gain           = cfg_wdata[GAIN_W-1:0];
                REG_THRESHOLD: cfg_next.threshold      = cfg_wdata[CUR_W-1:0];
                REG_WINDOW:    cfg_next.window_samples = cfg_wdata[FILL_W-1:0];
                REG_HOLDOFF:   cfg_next.holdoff_ms     = cfg_wdata[HOLD_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{enabled:        1'b0,
                         min_code:       '0,
                         gain:           '0,
                         threshold:      '0,
                         window_samples: FILL_W'(1),
                         holdoff_ms:     '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ccec_in_stage.sv =====
// ---------------------------------------------------------------------------
// ccec_in_stage
// Input register: clamps and scales the adc code to mA q8 on the way in.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccec_in_stage (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ccec_pkg::cfg_t                 cfg,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [1:0]                     s_op,
    input  wire logic [ccec_pkg::ADC_BITS-1:0]  s_adc_code,
    input  wire logic [ccec_pkg::TIME_W-1:0]    s_now_ms,
    input  wire logic                           pass_ready,
    output logic                                s1_valid,
    output ccec_pkg::item_t                     s1_item
);
    import ccec_pkg::*;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    item_t               item_reg;
    logic [ADC_BITS-1:0] code_diff;
    logic [PROD_W-1:0]   prod;
    logic [CUR_W-1:0]    cur;

    // clamp at min_code and scale by gain
    always_comb begin
        code_diff = (s_adc_code < cfg.min_code) ? '0 : (s_adc_code - cfg.min_code);
        prod      = PROD_W'(code_diff) * PROD_W'(cfg.gain);
        cur       = (|prod[PROD_W-1:CUR_W+CUR_FRAC_SH]) ? CUR_MAX
                                                        : prod[CUR_W+CUR_FRAC_SH-1:CUR_FRAC_SH];
    end

    // stage handshake
    assign s_ready       = !s1_valid_reg || pass_ready;
    assign s1_valid_next = s_ready ? s_valid : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // word capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.op     <= s_op;
            item_reg.now_ms <= s_now_ms;
            item_reg.cur    <= cur;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ccec_window.sv =====
// ---------------------------------------------------------------------------
// ccec_window
// Window accumulation, event decision with holdoff, and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ccec_window (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ccec_pkg::cfg_t                cfg,
    input  wire logic                          s1_valid,
    input  wire ccec_pkg::item_t               s1_item,
    output logic                               pass_ready,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ccec_pkg::CUR_W-1:0]         m_current_q8,
    output logic                               m_active,
    output logic [ccec_pkg::CNT_W-1:0]         m_event_count,
    output logic                               m_report_pending
);
    import ccec_pkg::*;

    // state doubles as the result register: it only moves with a new word
    logic              m_valid_reg;
    logic [SUM_W-1:0]  sum_reg,      sum_next;
    logic [FILL_W-1:0] fill_reg,     fill_next;
    logic [CUR_W-1:0]  current_reg,  current_next;
    logic              active_reg,   active_next;
    logic [CNT_W-1:0]  events_reg,   events_next;
    logic              pending_reg,  pending_next;
    logic              armed_reg,    armed_next;
    logic              fall_reg,     fall_next;
    logic [TIME_W-1:0] evt_time_reg, evt_time_next;

    logic              take;
    logic              sample;
    logic              armed_eff;
    logic [TIME_W-1:0] elapsed;
    logic [SUM_W-1:0]  sum_add;
    logic [FILL_W-1:0] fill_inc;
    logic              win_close;
    logic [SUM_W-1:0]  thr_prod;
    logic [SUM_W-1:0]  fall_lim;
    logic              hit;
    logic              armed_after;
    logic [CNT_W-1:0]  evt_inc;
    logic [CNT_W+SUM_W+CUR_W:0] state_tap;

    assign pass_ready = !m_valid_reg || m_ready;
    assign take       = s1_valid && pass_ready;
    assign sample     = take && (s1_item.op == OP_SAMPLE) && cfg.enabled;

    // holdoff re-arm check
    assign elapsed   = s1_item.now_ms - evt_time_reg;
    assign armed_eff = armed_reg
                    || (s1_item.now_ms < TIME_W'(cfg.holdoff_ms))
                    || (elapsed > TIME_W'(cfg.holdoff_ms));

    // window sum and exact average compares
    assign sum_add   = sum_reg + SUM_W'(s1_item.cur);
    assign fill_inc  = fill_reg + FILL_W'(1);
    assign win_close = (fill_inc >= cfg.window_samples) || (fill_inc == '0);
    assign thr_prod  = SUM_W'(cfg.threshold) * SUM_W'(fill_inc);
    assign fall_lim  = SUM_W'(fill_inc) << FALL_SH;
    assign hit       = (sum_add > thr_prod) && armed_eff && fall_reg;
    assign armed_after = hit ? 1'b0 : armed_eff;

    // next state
    always_comb begin
        sum_next      = sum_reg;
        fill_next     = fill_reg;
        current_next  = current_reg;
        active_next   = active_reg;
        events_next   = events_reg;
        pending_next  = pending_reg;
        armed_next    = armed_reg;
        fall_next     = fall_reg;
        evt_time_next = evt_time_reg;

        if (sample) begin
            current_next = s1_item.cur;
            armed_next   = armed_eff;
            if (win_close) begin
                active_next = hit;
                if (hit && !active_reg) begin
                    events_next  = events_reg + CNT_W'(1);
                    pending_next = 1'b1;
                end
                armed_next = armed_after;
                if (hit) begin
                    fall_next     = 1'b0;
                    evt_time_next = s1_item.now_ms;
                end
                if ((sum_add < fall_lim) && armed_after) begin
                    fall_next = 1'b1;
                end
                sum_next  = '0;
                fill_next = '0;
            end else begin
                sum_next  = sum_add;
                fill_next = fill_inc;
            end
        end else if (take && (s1_item.op == OP_FORCE)) begin
            events_next  = events_reg + CNT_W'(1);
            pending_next = 1'b1;
        end else if (take && (s1_item.op == OP_ACK) && cfg.enabled) begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sum_reg      <= '0;
            fill_reg     <= '0;
            current_reg  <= '0;
            active_reg   <= 1'b0;
            events_reg   <= '0;
            pending_reg  <= 1'b1;
            armed_reg    <= 1'b1;
            fall_reg     <= 1'b0;
            evt_time_reg <= '0;
        end else begin
            if (pass_ready) begin
                m_valid_reg <= s1_valid;
            end
            sum_reg      <= sum_next;
            fill_reg     <= fill_next;
            current_reg  <= current_next;
            active_reg   <= active_next;
            events_reg   <= events_next;
            pending_reg  <= pending_next;
            armed_reg    <= armed_next;
            fall_reg     <= fall_next;
            evt_time_reg <= evt_time_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_current_q8     = current_reg;
    assign m_active         = active_reg;
    assign m_event_count    = events_reg;
    assign m_report_pending = pending_reg;

    // checks
    assign evt_inc   = events_reg + CNT_W'(1);
    assign state_tap = {events_reg, sum_reg, current_reg, pending_reg};

    `ASSERT_SAME(a_evt_step, !$stable(events_reg), events_reg == $past(evt_inc), "count jumped")
    `ASSERT_SAME(a_evt_pend, !$stable(events_reg), pending_reg, "count change not reported")
    `ASSERT_NEXT(a_hold_stall, !take, $stable(state_tap), "state changed without a word")

endmodule

`default_nettype wire
